FILE: rtl/ppf_pkg.sv
// Shared types and constants for the PNG Paeth filter.
// No dependencies; imported by every module of the block.
package ppf_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd3216;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd2136;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified sample on its way from the front to the back.
    typedef struct packed {
        logic [SAMPLE_W-1:0] pixel;
        logic [SAMPLE_W-1:0] above;      // already zero on the first row
        logic                first_col;
        logic                eoi;
    } ppf_entry_t;

endpackage

FILE: rtl/ppf_front.sv
// Front part: accepts samples, tracks column and row, holds the line store.
// Depends on ppf_pkg; feeds ppf_queue with ppf_entry_t beats.
module ppf_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ppf_pkg::SAMPLE_W-1:0]      pixel,
    input  logic [ppf_pkg::CFG_W-1:0]         width_cfg,
    input  logic [ppf_pkg::CFG_W-1:0]         height_cfg,
    input  logic [ppf_pkg::QCNT_W-1:0]        q_count,
    output logic                              push,
    output ppf_pkg::ppf_entry_t               push_entry
);
    import ppf_pkg::*;

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WLW  = $clog2(MAX_WIDTH + 1);
    localparam int HLW  = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW = (WLW > CFG_W) ? WLW : CFG_W;
    localparam int CMPH = (HLW > CFG_W) ? HLW : CFG_W;

    logic [SAMPLE_W-1:0] line_mem [MAX_WIDTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_pixel_reg;
    logic                s1_first_col_reg;
    logic                s1_first_row_reg;
    logic                s1_eoi_reg;

    logic [CMPW-1:0]     w_lim;
    logic [CMPH-1:0]     h_lim;
    logic                accept;
    logic                end_row;
    logic                end_frame;
    logic [QCNT_W:0]     occupancy;

    // Zero acts as one, anything above the maximum acts as the maximum.
    always_comb
    begin
        if (width_cfg == '0)
            w_lim = CMPW'(1);
        else if (CMPW'(width_cfg) > CMPW'(MAX_WIDTH))
            w_lim = CMPW'(MAX_WIDTH);
        else
            w_lim = CMPW'(width_cfg);

        if (height_cfg == '0)
            h_lim = CMPH'(1);
        else if (CMPH'(height_cfg) > CMPH'(MAX_HEIGHT))
            h_lim = CMPH'(MAX_HEIGHT);
        else
            h_lim = CMPH'(height_cfg);
    end

    // Hold off while the queue could not absorb the beat in flight plus a new one.
    assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_reg);
    assign in_stall  = (occupancy >= (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept    = in_valid && !in_stall;

    assign end_row   = ((CMPW'(col_reg) + CMPW'(1)) >= w_lim);
    assign end_frame = ((CMPH'(row_reg) + CMPH'(1)) >= h_lim);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (end_row)
            begin
                col_next = '0;
                row_next = end_frame ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    // Read the entry above and overwrite it with the new sample in one access.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg       <= line_mem[col_reg];
            line_mem[col_reg] <= pixel;
            s1_pixel_reg      <= pixel;
            s1_first_col_reg  <= (col_reg == '0);
            s1_first_row_reg  <= (row_reg == '0);
            s1_eoi_reg        <= end_row && end_frame;
        end
    end

    assign push                 = s1_valid_reg;
    assign push_entry.pixel     = s1_pixel_reg;
    assign push_entry.above     = s1_first_row_reg ? '0 : rd_data_reg;
    assign push_entry.first_col = s1_first_col_reg;
    assign push_entry.eoi       = s1_eoi_reg;

    a_accept_then_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> push)
        else $error("accepted beat did not reach the queue");

endmodule

FILE: rtl/ppf_queue.sv
// Short in-order queue between the front and the back.
// Depends on ppf_pkg for the entry type and depth.
module ppf_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  ppf_pkg::ppf_entry_t           push_entry,
    input  logic                          pop,
    output logic                          head_valid,
    output ppf_pkg::ppf_entry_t           head_entry,
    output logic [ppf_pkg::QCNT_W-1:0]    count
);
    import ppf_pkg::*;

    ppf_entry_t          slot_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_mem[wr_ptr_reg] <= push_entry;
    end

    assign head_valid = (count_reg != '0);
    assign head_entry = slot_mem[rd_ptr_reg];
    assign count      = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < QCNT_W'(QUEUE_DEPTH)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

FILE: rtl/ppf_back.sv
// Back part: Paeth prediction, residual and output register.
// Depends on ppf_pkg; drains ppf_queue in order.
module ppf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  ppf_pkg::ppf_entry_t           head_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ppf_pkg::SAMPLE_W-1:0]  filtered,
    output logic                          end_of_image
);
    import ppf_pkg::*;

    logic [SAMPLE_W-1:0] left_reg;
    logic [SAMPLE_W-1:0] ul_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] filtered_reg;
    logic                eoi_reg;

    logic [SAMPLE_W-1:0] a, b, c, pred;
    logic signed [SAMPLE_W+1:0] d_a, d_b, d_c;
    logic [SAMPLE_W+1:0] pa, pb, pc;

    assign a = head_entry.first_col ? '0 : left_reg;
    assign b = head_entry.above;
    assign c = head_entry.first_col ? '0 : ul_reg;

    // Distances from p = a + b - c, written without forming p.
    always_comb
    begin
        d_a = $signed({2'b00, b}) - $signed({2'b00, c});
        d_b = $signed({2'b00, a}) - $signed({2'b00, c});
        d_c = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa  = (d_a < 0) ? 10'(-d_a) : 10'(d_a);
        pb  = (d_b < 0) ? 10'(-d_b) : 10'(d_b);
        pc  = (d_c < 0) ? 10'(-d_c) : 10'(d_c);
        if (pa <= pb && pa <= pc)
            pred = a;
        else if (pb <= pc)
            pred = b;
        else
            pred = c;
    end

    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            ul_reg        <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                left_reg      <= head_entry.pixel;
                ul_reg        <= b;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            filtered_reg <= head_entry.pixel - pred;
            eoi_reg      <= head_entry.eoi;
        end
    end

    assign out_valid    = out_valid_reg;
    assign filtered     = filtered_reg;
    assign end_of_image = eoi_reg;

    a_pop_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped beat not presented at output");

endmodule

FILE: rtl/png_paeth_filter.sv
// PNG Paeth filter: one 8-bit sample per beat in raster order, one residual out.
// Results pass the front stage register, a queue slot and the output register; one
// beat per cycle unless stalled, set by the single-port line store access on accept.
// Output stalls back up through a four-entry queue before input is stalled.
// Reset (rst_n low, asynchronous) clears counters, neighbors, queue and output valid;
// the line store is not cleared and needs no clearing pass.
module png_paeth_filter #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [ppf_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [ppf_pkg::CFG_W-1:0]        wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ppf_pkg::SAMPLE_W-1:0]     pixel,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ppf_pkg::SAMPLE_W-1:0]     filtered,
    output logic                             end_of_image
);
    import ppf_pkg::*;

    logic [CFG_W-1:0]  image_width_reg;
    logic [CFG_W-1:0]  image_height_reg;

    logic              push;
    ppf_entry_t        push_entry;
    logic              pop;
    logic              head_valid;
    ppf_entry_t        head_entry;
    logic [QCNT_W-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= wr_data;
                REG_IMAGE_HEIGHT: image_height_reg <= wr_data;
                default:          ;
            endcase
        end
    end

    ppf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .width_cfg  (image_width_reg),
        .height_cfg (image_height_reg),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry)
    );

    ppf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .count      (q_count)
    );

    ppf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered     (filtered),
        .end_of_image (end_of_image)
    );

endmodule
